/* sv/frame_region_scroll_defines.svh */
// ----------------------------------------------------------------------------
// frame region scroll assertion macros
// shared property wrappers, clocked on aclk and held off during reset
// ----------------------------------------------------------------------------
`ifndef FRAME_REGION_SCROLL_DEFINES_SVH
`define FRAME_REGION_SCROLL_DEFINES_SVH

// same-cycle implication
`define FRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/frs_pkg.sv */
// ----------------------------------------------------------------------------
// frs_pkg
// geometry, codes, beat types and controller interface of the region scroller
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int COLUMNS = 32;
    localparam int ROWS    = 8;
    localparam int DEPTH   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int X_W     = $clog2(COLUMNS);
    localparam int Y_W     = $clog2(ROWS);
    localparam int C_W     = (X_W > Y_W) ? X_W : Y_W;
    localparam int T_W     = C_W + 2;
    localparam int COORD_W = 8;
    localparam int PIX_W   = 24;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_MOVE  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [1:0]         direction;
        logic               wrap;
        logic [PIX_W-1:0]   pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             moved;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic wr_pixel;
        logic rd_pixel;
        logic rd_capture;
        logic sweep;
        logic mv_init;
        logic mv_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       span_zero;
        logic       sweep_last;
        logic       mv_done;
    } ctrl_sts_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [C_W-1:0] col,
                                                    input logic [C_W-1:0] row);
        return ADDR_W'(col) * ADDR_W'(ROWS) + ADDR_W'(row);
    endfunction

endpackage

/* sv/frame_region_scroll.sv */
// ----------------------------------------------------------------------------
// frame_region_scroll
// COLUMNS x ROWS frame of 24-bit pixels with write, read, clear and one-step
// region move; one result beat per command beat
// ----------------------------------------------------------------------------
// After reset the frame memory is zeroed by a sweep over all COLUMNS*ROWS
// cells before the first beat is taken. Every command then passes through
// accept, decode and result load; a read adds a registered memory read, a
// clear sweeps all COLUMNS*ROWS cells, and a move shifts the region one line
// at a time, where the lines are the columns (up, down) or rows (right, left)
// of the region. The frame memory has a single write port, which handles one
// pixel per cycle. A new command beat is taken while a previous result still
// waits on the output.
// ----------------------------------------------------------------------------
module frame_region_scroll (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  frs_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output frs_pkg::out_item_t m_data
);

    frs_pkg::ctrl_cmd_t cmd;
    frs_pkg::ctrl_sts_t sts;

    frs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    frs_datapath u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_data (m_data)
    );

endmodule

/* sv/frs_ram.sv */
// ----------------------------------------------------------------------------
// frs_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module frs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/frs_ctrl.sv */
// ----------------------------------------------------------------------------
// frs_ctrl
// command sequencer: init clear, decode, read wait, clear sweep, move, result
// ----------------------------------------------------------------------------
`include "frame_region_scroll_defines.svh"

module frs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  frs_pkg::ctrl_sts_t  sts,
    output frs_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_DECODE = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_SWEEP  = 7'b0010000,
        ST_MOVE   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (sts.command)
                    frs_pkg::CMD_WRITE: begin
                        cmd.wr_pixel = 1'b1;
                        state_next   = ST_DONE;
                    end
                    frs_pkg::CMD_READ: begin
                        cmd.rd_pixel = 1'b1;
                        state_next   = ST_READ;
                    end
                    frs_pkg::CMD_MOVE: begin
                        if (sts.span_zero) begin
                            state_next = ST_DONE;
                        end else begin
                            cmd.mv_init = 1'b1;
                            state_next  = ST_MOVE;
                        end
                    end
                    frs_pkg::CMD_CLEAR: begin
                        state_next = ST_SWEEP;
                    end
                endcase
            end
            ST_READ: begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_MOVE: begin
                cmd.mv_step = 1'b1;
                if (sts.mv_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `FRS_ASSERT_NEXT(a_accept_decode, s_valid && s_ready, state_reg == ST_DECODE, "accepted beat not decoded")
    `FRS_ASSERT_NEXT(a_zero_span, state_reg == ST_DECODE && sts.command == frs_pkg::CMD_MOVE && sts.span_zero, state_reg == ST_DONE, "zero-span move entered move loop")
    `FRS_ASSERT_NOW(a_read_issued, state_reg == ST_READ, $past(cmd.rd_pixel), "read capture without read issue")

endmodule

/* sv/frs_datapath.sv */
// ----------------------------------------------------------------------------
// frs_datapath
// frame memory, item capture with clamping, move address pipeline, result
// ----------------------------------------------------------------------------
`include "frame_region_scroll_defines.svh"

module frs_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  frs_pkg::in_item_t   s_data,
    input  frs_pkg::ctrl_cmd_t  cmd,
    output frs_pkg::ctrl_sts_t  sts,
    output frs_pkg::out_item_t  m_data
);

    localparam int XW = frs_pkg::X_W;
    localparam int YW = frs_pkg::Y_W;
    localparam int CW = frs_pkg::C_W;
    localparam int TW = frs_pkg::T_W;
    localparam int AW = frs_pkg::ADDR_W;
    localparam int KW = frs_pkg::COORD_W;
    localparam int PW = frs_pkg::PIX_W;
    localparam logic [KW-1:0] X_MAX = KW'(frs_pkg::COLUMNS - 1);
    localparam logic [KW-1:0] Y_MAX = KW'(frs_pkg::ROWS - 1);
    localparam logic [AW-1:0] A_LAST = AW'(frs_pkg::DEPTH - 1);

    // captured item
    logic [1:0]    cmd_reg;
    logic [XW-1:0] x0_reg;
    logic [YW-1:0] y0_reg;
    logic [XW-1:0] x1_reg;
    logic [YW-1:0] y1_reg;
    logic [1:0]    dir_reg;
    logic          wrap_reg;
    logic [PW-1:0] pix_reg;

    // move and sweep state
    logic [AW-1:0] clr_addr_reg;
    logic [CW-1:0] line_reg;
    logic [CW-1:0] pos_reg;
    logic [TW-1:0] t_reg;
    logic [AW-1:0] addr_d1_reg;
    logic [AW-1:0] addr_d2_reg;
    logic [PW-1:0] keep_reg;

    // result
    logic [PW-1:0]      res_pixel_reg;
    logic               res_moved_reg;
    frs_pkg::out_item_t m_data_reg;

    logic [KW-1:0] x0_c, y0_c, x1_m, y1_m, x1_c, y1_c;
    logic          vertical, pos_fwd;
    logic [CW-1:0] x0w, y0w, x1w, y1w;
    logic [CW-1:0] span, line_start, line_end, start_pos;
    logic [TW-1:0] span_t;
    logic [AW-1:0] mv_addr, pix_addr;
    logic          mv_rd, mv_wr, mv_last, sweep_last;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [PW-1:0] mem_wdata, mem_rdata;

    // clamp on capture
    always_comb begin
        x0_c = (s_data.x_start > X_MAX) ? X_MAX : s_data.x_start;
        y0_c = (s_data.y_start > Y_MAX) ? Y_MAX : s_data.y_start;
        x1_m = (s_data.x_end > X_MAX) ? X_MAX : s_data.x_end;
        y1_m = (s_data.y_end > Y_MAX) ? Y_MAX : s_data.y_end;
        x1_c = (x1_m < x0_c) ? x0_c : x1_m;
        y1_c = (y1_m < y0_c) ? y0_c : y1_m;
    end

    always_comb begin
        x0w        = CW'(x0_reg);
        y0w        = CW'(y0_reg);
        x1w        = CW'(x1_reg);
        y1w        = CW'(y1_reg);
        vertical   = (dir_reg == frs_pkg::DIR_UP) || (dir_reg == frs_pkg::DIR_DOWN);
        pos_fwd    = (dir_reg == frs_pkg::DIR_DOWN) || (dir_reg == frs_pkg::DIR_LEFT);
        span       = vertical ? (y1w - y0w) : (x1w - x0w);
        span_t     = TW'(span);
        line_start = vertical ? x0w : y0w;
        line_end   = vertical ? x1w : y1w;
        unique case (dir_reg)
            frs_pkg::DIR_UP:    start_pos = y1w;
            frs_pkg::DIR_DOWN:  start_pos = y0w;
            frs_pkg::DIR_RIGHT: start_pos = x1w;
            frs_pkg::DIR_LEFT:  start_pos = x0w;
        endcase
        mv_addr    = vertical ? frs_pkg::cell_addr(line_reg, pos_reg)
                              : frs_pkg::cell_addr(pos_reg, line_reg);
        pix_addr   = frs_pkg::cell_addr(x0w, y0w);
        mv_rd      = (t_reg <= span_t);
        mv_wr      = (t_reg >= TW'(2));
        mv_last    = (t_reg == span_t + TW'(2));
        sweep_last = (clr_addr_reg == A_LAST);
    end

    // memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = pix_addr;
        priority if (cmd.sweep) begin
            mem_we = 1'b1;
        end else if (cmd.wr_pixel) begin
            mem_we    = 1'b1;
            mem_waddr = pix_addr;
            mem_wdata = pix_reg;
        end else if (cmd.mv_step) begin
            mem_we    = mv_wr;
            mem_waddr = addr_d2_reg;
            mem_wdata = mv_last ? (wrap_reg ? keep_reg : '0) : mem_rdata;
        end
        priority if (cmd.rd_pixel) begin
            mem_re = 1'b1;
        end else if (cmd.mv_step) begin
            mem_re    = mv_rd;
            mem_raddr = mv_addr;
        end
    end

    frs_ram #(
        .WIDTH(PW),
        .DEPTH(frs_pkg::DEPTH)
    ) u_frame_ram (
        .aclk   (aclk),
        .wr_en  (mem_we),
        .wr_addr(mem_waddr),
        .wr_data(mem_wdata),
        .rd_en  (mem_re),
        .rd_addr(mem_raddr),
        .rd_data(mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            res_moved_reg <= 1'b0;
        end else begin
            if (cmd.sweep) begin
                clr_addr_reg <= sweep_last ? '0 : clr_addr_reg + AW'(1);
            end
            if (cmd.load) begin
                res_moved_reg <= 1'b0;
            end else if (cmd.mv_init) begin
                res_moved_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg       <= s_data.command;
            x0_reg        <= XW'(x0_c);
            y0_reg        <= YW'(y0_c);
            x1_reg        <= XW'(x1_c);
            y1_reg        <= YW'(y1_c);
            dir_reg       <= s_data.direction;
            wrap_reg      <= s_data.wrap;
            pix_reg       <= s_data.pixel_in;
            res_pixel_reg <= '0;
        end
        if (cmd.rd_capture) begin
            res_pixel_reg <= mem_rdata;
        end
        if (cmd.mv_init) begin
            line_reg <= line_start;
            pos_reg  <= start_pos;
            t_reg    <= '0;
        end
        if (cmd.mv_step) begin
            addr_d1_reg <= mv_addr;
            addr_d2_reg <= addr_d1_reg;
            if (t_reg == TW'(1)) begin
                keep_reg <= mem_rdata;
            end
            if (mv_last) begin
                t_reg    <= '0;
                pos_reg  <= start_pos;
                line_reg <= line_reg + CW'(1);
            end else begin
                t_reg <= t_reg + TW'(1);
                if (t_reg < span_t) begin
                    pos_reg <= pos_fwd ? pos_reg + CW'(1) : pos_reg - CW'(1);
                end
            end
        end
        if (cmd.out_load) begin
            m_data_reg.pixel_out <= res_pixel_reg;
            m_data_reg.moved     <= res_moved_reg;
        end
    end

    assign sts.command    = cmd_reg;
    assign sts.span_zero  = (span == '0);
    assign sts.sweep_last = sweep_last;
    assign sts.mv_done    = mv_last && (line_reg == line_end);
    assign m_data         = m_data_reg;

    `FRS_ASSERT_NOW(a_port_clash, mem_we && mem_re, mem_waddr != mem_raddr, "frame ram read and write collide")
    `FRS_ASSERT_NOW(a_step_bound, cmd.mv_step, t_reg <= span_t + TW'(2), "move step counter overran line")
    `FRS_ASSERT_NOW(a_moved_cmd, res_moved_reg, cmd_reg == frs_pkg::CMD_MOVE, "moved flag set for non-move beat")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame region scroll testbench
// drives write, read, move and clear beats into the frame store, predicts
// each result beat from a private copy of the frame and checks it field by
// field, under phases of sender idling and receiver stalls
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int PHASE_BEATS  = 150;
    localparam int DRAIN_CYCLES = 50;

    class frame_model;
        logic [frs_pkg::PIX_W-1:0] cells [frs_pkg::DEPTH];
        frs_pkg::out_item_t expected_q [$];
        int failures;
        int beats;
        int reads;
        int shifts;
        int clears;

        function new();
            foreach (cells[i]) cells[i] = '0;
            failures = 0;
            beats = 0;
            reads = 0;
            shifts = 0;
            clears = 0;
        endfunction

        function int at(int x, int y);
            return x * frs_pkg::ROWS + y;
        endfunction

        function int clamp(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function bit shift_region(int x0, int y0, int x1, int y1,
                                  logic [1:0] dir, logic wrap);
            logic [frs_pkg::PIX_W-1:0] spill;
            if (dir == frs_pkg::DIR_UP || dir == frs_pkg::DIR_DOWN) begin
                if (y1 == y0) return 1'b0;
                for (int x = x0; x <= x1; x++) begin
                    if (dir == frs_pkg::DIR_UP) begin
                        spill = cells[at(x, y1)];
                        for (int y = y1; y > y0; y--) cells[at(x, y)] = cells[at(x, y - 1)];
                        cells[at(x, y0)] = wrap ? spill : '0;
                    end else begin
                        spill = cells[at(x, y0)];
                        for (int y = y0; y < y1; y++) cells[at(x, y)] = cells[at(x, y + 1)];
                        cells[at(x, y1)] = wrap ? spill : '0;
                    end
                end
            end else begin
                if (x1 == x0) return 1'b0;
                for (int y = y0; y <= y1; y++) begin
                    if (dir == frs_pkg::DIR_RIGHT) begin
                        spill = cells[at(x1, y)];
                        for (int x = x1; x > x0; x--) cells[at(x, y)] = cells[at(x - 1, y)];
                        cells[at(x0, y)] = wrap ? spill : '0;
                    end else begin
                        spill = cells[at(x0, y)];
                        for (int x = x0; x < x1; x++) cells[at(x, y)] = cells[at(x + 1, y)];
                        cells[at(x1, y)] = wrap ? spill : '0;
                    end
                end
            end
            return 1'b1;
        endfunction

        function void note_command(frs_pkg::in_item_t item);
            int x0;
            int y0;
            int x1;
            int y1;
            frs_pkg::out_item_t res;
            x0 = clamp(int'(item.x_start), 0, frs_pkg::COLUMNS - 1);
            y0 = clamp(int'(item.y_start), 0, frs_pkg::ROWS - 1);
            x1 = clamp(int'(item.x_end), x0, frs_pkg::COLUMNS - 1);
            y1 = clamp(int'(item.y_end), y0, frs_pkg::ROWS - 1);
            res = '0;
            beats++;
            case (item.command)
                frs_pkg::CMD_WRITE: begin
                    cells[at(x0, y0)] = item.pixel_in;
                end
                frs_pkg::CMD_READ: begin
                    res.pixel_out = cells[at(x0, y0)];
                    reads++;
                end
                frs_pkg::CMD_MOVE: begin
                    res.moved = shift_region(x0, y0, x1, y1, item.direction, item.wrap);
                    if (res.moved) shifts++;
                end
                default: begin
                    foreach (cells[i]) cells[i] = '0;
                    clears++;
                end
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(frs_pkg::out_item_t got);
            frs_pkg::out_item_t want;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing pending: pixel_out %h moved %0d",
                       got.pixel_out, got.moved);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got.pixel_out !== want.pixel_out) begin
                $error("pixel_out: expected %h, actual %h", want.pixel_out, got.pixel_out);
                failures++;
            end
            if (got.moved !== want.moved) begin
                $error("moved: expected %0d, actual %0d", want.moved, got.moved);
                failures++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    frs_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    frs_pkg::out_item_t m_data;

    frame_model model = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    frame_region_scroll u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check accepted beats, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) model.check_result(m_data);
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic frs_pkg::in_item_t beat_of(logic [1:0] cmd, int xs, int ys,
                                                  int xe, int ye, logic [1:0] dir,
                                                  logic wrap,
                                                  logic [frs_pkg::PIX_W-1:0] pix);
        frs_pkg::in_item_t item;
        item.command   = cmd;
        item.x_start   = frs_pkg::COORD_W'(xs);
        item.y_start   = frs_pkg::COORD_W'(ys);
        item.x_end     = frs_pkg::COORD_W'(xe);
        item.y_end     = frs_pkg::COORD_W'(ye);
        item.direction = dir;
        item.wrap      = wrap;
        item.pixel_in  = pix;
        return item;
    endfunction

    // mostly in range, sometimes anywhere in the 8-bit field
    function automatic int pick_coord(int span);
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, span - 1);
        return $urandom_range(0, 255);
    endfunction

    function automatic frs_pkg::in_item_t random_beat();
        int roll;
        logic [1:0] cmd;
        roll = $urandom_range(0, 99);
        if (roll < 38)      cmd = frs_pkg::CMD_WRITE;
        else if (roll < 72) cmd = frs_pkg::CMD_READ;
        else if (roll < 95) cmd = frs_pkg::CMD_MOVE;
        else                cmd = frs_pkg::CMD_CLEAR;
        return beat_of(cmd, pick_coord(frs_pkg::COLUMNS), pick_coord(frs_pkg::ROWS),
                       pick_coord(frs_pkg::COLUMNS), pick_coord(frs_pkg::ROWS),
                       2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       frs_pkg::PIX_W'($urandom()));
    endfunction

    // called right after a rising edge; returns at the edge the beat is taken
    task automatic send_beat(frs_pkg::in_item_t item);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        model.note_command(item);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (model.pending() != 0);
    endtask

    function automatic logic [frs_pkg::PIX_W-1:0] any_pix();
        return frs_pkg::PIX_W'($urandom());
    endfunction

    int idle_set  [5] = '{0, 45, 0, 23, 0};
    int stall_set [5] = '{0, 0, 45, 23, 0};

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(beat_of(frs_pkg::CMD_READ, 0, 0, 0, 0,
                          frs_pkg::DIR_UP, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_WRITE, 0, 0, 0, 0,
                          frs_pkg::DIR_UP, 1'b0, 24'hFFFFFF));
        send_beat(beat_of(frs_pkg::CMD_WRITE, 255, 255, 0, 0,
                          frs_pkg::DIR_LEFT, 1'b1, 24'h123456));
        send_beat(beat_of(frs_pkg::CMD_WRITE, 31, 0, 0, 0,
                          frs_pkg::DIR_DOWN, 1'b0, 24'h800001));
        send_beat(beat_of(frs_pkg::CMD_WRITE, 0, 7, 0, 0,
                          frs_pkg::DIR_RIGHT, 1'b1, 24'h7F00FE));
        send_beat(beat_of(frs_pkg::CMD_READ, 255, 255, 255, 255,
                          frs_pkg::DIR_LEFT, 1'b1, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_READ, 0, 0, 0, 0,
                          frs_pkg::DIR_UP, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 0, 0, 255, 255,
                          frs_pkg::DIR_UP, 1'b1, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_READ, 0, 0, 0, 0,
                          frs_pkg::DIR_UP, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 0, 0, 255, 255,
                          frs_pkg::DIR_DOWN, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 0, 0, 31, 7,
                          frs_pkg::DIR_RIGHT, 1'b1, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 3, 2, 20, 6,
                          frs_pkg::DIR_LEFT, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 4, 5, 200, 5,
                          frs_pkg::DIR_UP, 1'b1, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 10, 1, 2, 6,
                          frs_pkg::DIR_RIGHT, 1'b1, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 0, 6, 31, 1,
                          frs_pkg::DIR_DOWN, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 2, 1, 9, 4,
                          frs_pkg::DIR_UP, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 0, 0, 31, 0,
                          frs_pkg::DIR_LEFT, 1'b1, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_READ, 31, 0, 0, 0,
                          frs_pkg::DIR_UP, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_READ, 0, 0, 0, 0,
                          frs_pkg::DIR_UP, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_CLEAR, 17, 3, 9, 2,
                          frs_pkg::DIR_RIGHT, 1'b1, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_READ, 31, 7, 0, 0,
                          frs_pkg::DIR_UP, 1'b0, any_pix()));
        send_beat(beat_of(frs_pkg::CMD_MOVE, 0, 0, 31, 7,
                          frs_pkg::DIR_DOWN, 1'b1, any_pix()));
        drain();

        for (int p = 0; p < 5; p++) begin
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            for (int n = 0; n < PHASE_BEATS; n++) send_beat(random_beat());
            drain();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d command beats: %0d reads, %0d region shifts, %0d clears",
                 model.beats, model.reads, model.shifts, model.clears);
        $display("idle phases: none, sender 45%%, receiver 45%%, both 23%%, none");
        if (model.failures == 0 && model.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
